// File: rtl/tsfrs_pkg.sv
// ----------------------------------------------------------------------------
// TDMA slot frame ring scheduler - shared package
// Word types, operation and group codes, and the command word that passes
// from the front end to the back end through the command queue.
// ----------------------------------------------------------------------------
package tsfrs_pkg;

   // Default number of frame descriptors held in the ring
   localparam int DEFAULT_RING_DEPTH = 4;

   // Depth of the command queue between front and back end
   localparam int CMD_Q_DEPTH = 2;

   // Request operation codes
   localparam logic [1:0] OP_PUSH  = 2'd0;
   localparam logic [1:0] OP_JOIN  = 2'd1;
   localparam logic [1:0] OP_LEAVE = 2'd2;
   localparam logic [1:0] OP_TICK  = 2'd3;

   // Group state codes
   localparam logic [1:0] GS_NONE   = 2'd0;
   localparam logic [1:0] GS_CLAIM  = 2'd1;
   localparam logic [1:0] GS_JOINED = 2'd2;

   // Request word
   typedef struct packed {
      logic [1:0] op;
      logic [7:0] frame_id;
      logic       vad;
      logic [1:0] group_state;
      logic [2:0] own_slot;
      logic       coord_role;
   } req_word_type;

   // Response word, one per slot tick taken inside the group
   typedef struct packed {
      logic        send;
      logic        beacon_flag;
      logic        join_flag;
      logic        leave_flag;
      logic        vad_flag;
      logic        cur_valid;
      logic [7:0]  cur_frame;
      logic        prev_valid;
      logic [7:0]  prev_frame;
      logic [15:0] seq;
      logic [15:0] superframe;
   } rsp_word_type;

   // Classified command kinds
   typedef enum logic [2:0] {
      CMD_PUSH     = 3'd0,
      CMD_JOIN     = 3'd1,
      CMD_LEAVE    = 3'd2,
      CMD_TICK_IN  = 3'd3,
      CMD_TICK_OUT = 3'd4
   } cmd_kind_type;

   // Command word carried through the queue
   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   frame_id;
      logic         vad;
      logic         joined;
      logic         beacon_slot;
   } cmd_word_type;

   // Ring entry
   typedef struct packed {
      logic [7:0] frame_id;
      logic       vad;
   } ring_entry_type;

endpackage

// File: rtl/tdma_slot_frame_ring_scheduler.sv
// ----------------------------------------------------------------------------
// TDMA slot frame ring scheduler - top level
// Push, join and leave words are taken one per cycle while the command queue is
// not full; a slot tick inside the group yields one response word, which passes
// through the command queue, the registered ring read and the response register.
// A slot tick inside the group waits in the tick state for the registered ring
// read and a free response register; every other word is carried out in idle.
// Synchronous active-high reset clears pointers, counters, flags and queues;
// the ring contents are not cleared and are read only after being written.
// ----------------------------------------------------------------------------
module tdma_slot_frame_ring_scheduler #(
   parameter int RING_DEPTH = tsfrs_pkg::DEFAULT_RING_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  tsfrs_pkg::req_word_type req_word,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output tsfrs_pkg::rsp_word_type rsp_word
);
   import tsfrs_pkg::*;

   logic         q_wr;
   logic         q_full;
   logic         q_empty;
   logic         q_rd;
   cmd_word_type q_wr_word;
   cmd_word_type q_rd_word;

   // Classifier
   tsfrs_front u_front (
      .req_push (req_push),
      .req_full (req_full),
      .req_word (req_word),
      .q_wr     (q_wr),
      .q_word   (q_wr_word),
      .q_full   (q_full)
   );

   // Command queue
   tsfrs_cmd_fifo u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_wr),
      .wr_word (q_wr_word),
      .full    (q_full),
      .rd_en   (q_rd),
      .rd_word (q_rd_word),
      .empty   (q_empty)
   );

   // Ring and slot engine
   tsfrs_back #(
      .RING_DEPTH (RING_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!q_empty),
      .cmd_word  (q_rd_word),
      .cmd_pop   (q_rd),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

endmodule

// File: rtl/tsfrs_front.sv
// ----------------------------------------------------------------------------
// TDMA slot frame ring scheduler - front end
// Takes request words, classifies them into commands and writes them into
// the command queue. Leave requests outside the joined state are dropped.
// ----------------------------------------------------------------------------
module tsfrs_front (
   input  logic                   req_push,
   output logic                   req_full,
   input  tsfrs_pkg::req_word_type req_word,
   output logic                   q_wr,
   output tsfrs_pkg::cmd_word_type q_word,
   input  logic                   q_full
);
   import tsfrs_pkg::*;

   logic in_group;
   logic keep;

   // Group membership for ticks: claiming or joined
   assign in_group = (req_word.group_state == GS_CLAIM) ||
                     (req_word.group_state == GS_JOINED);

   // Classify the request word
   always_comb begin
      q_word.frame_id    = req_word.frame_id;
      q_word.vad         = req_word.vad;
      q_word.joined      = (req_word.group_state == GS_JOINED);
      q_word.beacon_slot = (req_word.own_slot == 3'd0) && req_word.coord_role;
      keep               = 1'b1;
      unique case (req_word.op)
         OP_PUSH:  q_word.kind = CMD_PUSH;
         OP_JOIN:  q_word.kind = CMD_JOIN;
         OP_LEAVE: begin
            q_word.kind = CMD_LEAVE;
            keep        = (req_word.group_state == GS_JOINED);
         end
         OP_TICK:  q_word.kind = in_group ? CMD_TICK_IN : CMD_TICK_OUT;
         default:  q_word.kind = CMD_TICK_OUT;
      endcase
   end

   // Accepted words that matter go into the queue
   assign req_full = q_full;
   assign q_wr     = req_push && !q_full && keep;

endmodule

// File: rtl/tsfrs_cmd_fifo.sv
// ----------------------------------------------------------------------------
// TDMA slot frame ring scheduler - command queue
// Short queue of classified command words between front and back end.
// ----------------------------------------------------------------------------
module tsfrs_cmd_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  tsfrs_pkg::cmd_word_type wr_word,
   output logic                   full,
   input  logic                   rd_en,
   output tsfrs_pkg::cmd_word_type rd_word,
   output logic                   empty
);
   import tsfrs_pkg::*;

   localparam int PTR_W = $clog2(CMD_Q_DEPTH);
   localparam int CNT_W = $clog2(CMD_Q_DEPTH + 1);

   cmd_word_type     entry_ff [CMD_Q_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(CMD_Q_DEPTH - 1)) begin
         return '0;
      end
      return p + PTR_W'(1);
   endfunction

   assign full    = (count_ff == CNT_W'(CMD_Q_DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_word = entry_ff[rd_ptr_ff];

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_en ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = rd_en ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!wr_en && rd_en) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset needed
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_word;
      end
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CMD_Q_DEPTH))
      else $error("command queue count out of range");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !full)
      else $error("command queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> !empty)
      else $error("command queue read while empty");
`endif

endmodule

// File: rtl/tsfrs_back.sv
// ----------------------------------------------------------------------------
// TDMA slot frame ring scheduler - back end
// Holds the descriptor ring, sequence and superframe counters and the
// pending flags. Carries out commands and builds the slot response word.
// ----------------------------------------------------------------------------
module tsfrs_back #(
   parameter int RING_DEPTH = tsfrs_pkg::DEFAULT_RING_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   input  tsfrs_pkg::cmd_word_type cmd_word,
   output logic                   cmd_pop,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output tsfrs_pkg::rsp_word_type rsp_word
);
   import tsfrs_pkg::*;

   localparam int PTR_W = $clog2(RING_DEPTH);
   localparam int CNT_W = $clog2(RING_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_TICK = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [15:0]      next_seq_ff, next_seq_in;
   logic [15:0]      frame_cnt_ff, frame_cnt_in;
   logic             join_ff, join_in;
   logic             leave_ff, leave_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_word_type     rsp_word_ff, rsp_word_in;
   logic             tick_joined_ff, tick_joined_in;
   logic             tick_bslot_ff, tick_bslot_in;

   ring_entry_type   ring_mem [RING_DEPTH];
   ring_entry_type   rd_old_ff;
   ring_entry_type   rd_new_ff;
   logic             ring_we;

   logic             beacon;
   logic             have_one;
   logic             take_two;
   logic             issue;
   rsp_word_type     tick_word;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(RING_DEPTH - 1)) begin
         return '0;
      end
      return p + PTR_W'(1);
   endfunction

   // Slot word built from the registered ring reads
   always_comb begin
      beacon   = tick_bslot_ff && !frame_cnt_ff[0];
      have_one = (fill_ff != '0);
      take_two = !beacon && (fill_ff >= CNT_W'(2));

      tick_word.beacon_flag = beacon;
      tick_word.join_flag   = join_ff;
      tick_word.leave_flag  = leave_ff;
      tick_word.superframe  = frame_cnt_ff;
      tick_word.cur_valid   = have_one;
      tick_word.prev_valid  = have_one && take_two;
      tick_word.vad_flag    = 1'b0;
      tick_word.cur_frame   = '0;
      tick_word.prev_frame  = '0;
      tick_word.seq         = next_seq_ff;
      if (have_one && take_two) begin
         tick_word.vad_flag   = rd_old_ff.vad || rd_new_ff.vad;
         tick_word.cur_frame  = rd_new_ff.frame_id;
         tick_word.prev_frame = rd_old_ff.frame_id;
         tick_word.seq        = next_seq_ff + 16'd1;
      end else if (have_one) begin
         tick_word.vad_flag  = rd_old_ff.vad;
         tick_word.cur_frame = rd_old_ff.frame_id;
      end
      tick_word.send = have_one || beacon || join_ff || leave_ff || tick_joined_ff;
   end

   // Command sequencer
   always_comb begin
      state_in       = state_ff;
      wr_ptr_in      = wr_ptr_ff;
      rd_ptr_in      = rd_ptr_ff;
      fill_in        = fill_ff;
      next_seq_in    = next_seq_ff;
      frame_cnt_in   = frame_cnt_ff;
      join_in        = join_ff;
      leave_in       = leave_ff;
      tick_joined_in = tick_joined_ff;
      tick_bslot_in  = tick_bslot_ff;
      rsp_word_in    = rsp_word_ff;
      cmd_pop        = 1'b0;
      ring_we        = 1'b0;
      issue          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               unique case (cmd_word.kind)
                  CMD_PUSH: begin
                     ring_we   = 1'b1;
                     wr_ptr_in = ptr_inc(wr_ptr_ff);
                     if (fill_ff == CNT_W'(RING_DEPTH)) begin
                        // full: the oldest entry is overwritten
                        rd_ptr_in = ptr_inc(rd_ptr_ff);
                     end else begin
                        fill_in = fill_ff + CNT_W'(1);
                     end
                  end
                  CMD_JOIN:  join_in = 1'b1;
                  CMD_LEAVE: leave_in = 1'b1;
                  CMD_TICK_IN: begin
                     // ring read is registered: finish in the tick state
                     state_in       = ST_TICK;
                     tick_joined_in = cmd_word.joined;
                     tick_bslot_in  = cmd_word.beacon_slot;
                  end
                  CMD_TICK_OUT: frame_cnt_in = frame_cnt_ff + 16'd1;
                  default: ;
               endcase
            end
         end
         ST_TICK: begin
            if (!rsp_valid_ff || rsp_pop) begin
               issue        = 1'b1;
               rsp_word_in  = tick_word;
               state_in     = ST_IDLE;
               join_in      = 1'b0;
               leave_in     = 1'b0;
               frame_cnt_in = frame_cnt_ff + 16'd1;
               if (have_one && take_two) begin
                  rd_ptr_in   = ptr_inc(ptr_inc(rd_ptr_ff));
                  fill_in     = fill_ff - CNT_W'(2);
                  next_seq_in = next_seq_ff + 16'd2;
               end else if (have_one) begin
                  rd_ptr_in   = ptr_inc(rd_ptr_ff);
                  fill_in     = fill_ff - CNT_W'(1);
                  next_seq_in = next_seq_ff + 16'd1;
               end else begin
                  next_seq_in = next_seq_ff + 16'd1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Response holding register
   assign rsp_valid_in = issue || (rsp_valid_ff && !rsp_pop);
   assign rsp_empty    = !rsp_valid_ff;
   assign rsp_word     = rsp_word_ff;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         fill_ff      <= '0;
         next_seq_ff  <= '0;
         frame_cnt_ff <= '0;
         join_ff      <= 1'b0;
         leave_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         fill_ff      <= fill_in;
         next_seq_ff  <= next_seq_in;
         frame_cnt_ff <= frame_cnt_in;
         join_ff      <= join_in;
         leave_ff     <= leave_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rsp_word_ff    <= rsp_word_in;
      tick_joined_ff <= tick_joined_in;
      tick_bslot_ff  <= tick_bslot_in;
   end

   // Descriptor ring: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[wr_ptr_ff] <= '{frame_id: cmd_word.frame_id, vad: cmd_word.vad};
      end
      rd_old_ff <= ring_mem[rd_ptr_ff];
      rd_new_ff <= ring_mem[ptr_inc(rd_ptr_ff)];
   end

`ifndef SYNTHESIS
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(RING_DEPTH))
      else $error("ring fill count out of range");
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff <= PTR_W'(RING_DEPTH - 1)) && (rd_ptr_ff <= PTR_W'(RING_DEPTH - 1)))
      else $error("ring pointer out of range");
   a_seq_moves: assert property (@(posedge clock) disable iff (reset)
      issue |=> (next_seq_ff != $past(next_seq_ff)))
      else $error("sequence number not advanced after slot word");
   a_beacon_prev: assert property (@(posedge clock) disable iff (reset)
      issue |-> !(tick_word.beacon_flag && tick_word.prev_valid))
      else $error("previous frame area used on a beacon slot");
   a_no_cmd_in_tick: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TICK) |-> !cmd_pop)
      else $error("command taken while a slot word is pending");
`endif

endmodule
